// ===== rtl/core/cas_pkg.sv =====
// Shared types and constants of the chord arpeggio sequencer.
package cas_pkg;

   localparam int MAX_NOTES_DEFAULT = 16;
   localparam int NOTE_W = 7;
   localparam int MODE_W = 2;

   // Arpeggio order held in the pattern_mode register.
   typedef enum logic [MODE_W-1:0] {
      MODE_UP      = 2'd0,
      MODE_DOWN    = 2'd1,
      MODE_UP_DOWN = 2'd2,
      MODE_DOWN_UP = 2'd3
   } pattern_mode_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_EMIT_SETUP,
      ST_EMIT_RD
   } seq_state_type;

   typedef struct packed {
      logic [NOTE_W-1:0] note_number;
      logic              chord_end;
   } req_type;

   typedef struct packed {
      logic [NOTE_W-1:0] out_note;
      logic              last_of_run;
      logic              overflow;
   } rsp_type;

endpackage

// ===== rtl/core/cas_note_ram.sv =====
// Note store: one write port and one registered read port.
module cas_note_ram #(
   parameter int DEPTH = cas_pkg::MAX_NOTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [cas_pkg::NOTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [cas_pkg::NOTE_W-1:0] rd_data
);

   logic [cas_pkg::NOTE_W-1:0] mem_ff [DEPTH];
   logic [cas_pkg::NOTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/chord_arpeggio_sequencer.sv =====
// Chord arpeggio sequencer: sorted note set and arpeggio emission sequencer.
//
// Each transfer on the req_ channel carries one note of a chord and a flag
// that marks the chord's final note. The block keeps the distinct notes in
// ascending order in a small RAM; a repeated note is ignored, and a new note
// that arrives when MAX_NOTES notes are already held is dropped and raises the
// overflow flag of the chord. When the final note has been inserted, the block
// sends the arpeggio on the rsp_ channel in the order set by the csr_ register
// (up, down, up-down or down-up, ends not repeated), one transfer per note,
// with last_of_run on the final one, and then clears the set.
//
// One comparator walks the RAM. The search reads and compares, in turn, each
// stored note below the new one. A note that goes on top needs one more check
// and one write; a note that goes lower needs the compare that finds its place,
// a read and a write for each note that moves up one place, and its own write.
// A repeat ends the search. req_ready is low for the whole of this work.
// Emission reads each result through the single registered RAM read port.
// A stalled result waits in the output register and holds the sequencer;
// the last one may still wait there while the next chord's first note is taken.
// Synchronous reset empties the note set, clears the overflow flag, selects
// the up pattern and drops any pending result. No clearing pass is needed.
module chord_arpeggio_sequencer #(
   parameter int MAX_NOTES = cas_pkg::MAX_NOTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  cas_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cas_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [cas_pkg::MODE_W-1:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_NOTES);
   localparam int CNT_W  = $clog2(MAX_NOTES + 1);
   localparam int SEQ_W  = CNT_W + 1;

   cas_pkg::seq_state_type    state_ff, state_in;
   cas_pkg::pattern_mode_type mode_ff;
   logic [cas_pkg::NOTE_W-1:0] note_ff, note_in;
   logic                       end_ff, end_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       dropped_ff, dropped_in;
   logic [CNT_W-1:0]           ptr_ff, ptr_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic [SEQ_W-1:0]           seq_ff, seq_in;
   logic [SEQ_W-1:0]           len_ff, len_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cas_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [cas_pkg::NOTE_W-1:0] ram_wdata;
   logic                       ram_re;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [cas_pkg::NOTE_W-1:0] ram_rdata;

   logic [SEQ_W-1:0]           n_ext;
   logic [SEQ_W-1:0]           emit_idx;
   logic [CNT_W-1:0]           ptr_dec;
   logic                       rsp_free;
   cas_pkg::seq_state_type     done_state;

   cas_note_ram #(
      .DEPTH (MAX_NOTES)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Position of the j-th result of the arpeggio within the sorted set.
   always_comb begin
      n_ext = SEQ_W'(count_ff);
      unique case (mode_ff)
         cas_pkg::MODE_UP: begin
            emit_idx = seq_ff;
         end
         cas_pkg::MODE_DOWN: begin
            emit_idx = n_ext - SEQ_W'(1) - seq_ff;
         end
         cas_pkg::MODE_UP_DOWN: begin
            if (seq_ff < n_ext) begin
               emit_idx = seq_ff;
            end else begin
               emit_idx = (n_ext << 1) - SEQ_W'(2) - seq_ff;
            end
         end
         cas_pkg::MODE_DOWN_UP: begin
            if (seq_ff < n_ext) begin
               emit_idx = n_ext - SEQ_W'(1) - seq_ff;
            end else begin
               emit_idx = seq_ff - n_ext + SEQ_W'(1);
            end
         end
         default: begin
            emit_idx = seq_ff;
         end
      endcase
   end

   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign done_state = end_ff ? cas_pkg::ST_EMIT_SETUP : cas_pkg::ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      note_in      = note_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff[ADDR_W-1:0];
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = ptr_ff[ADDR_W-1:0];
      req_ready    = 1'b0;

      unique case (state_ff)
         cas_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               note_in  = req_data.note_number;
               end_in   = req_data.chord_end;
               ptr_in   = '0;
               seq_in   = '0;
               state_in = cas_pkg::ST_SEARCH_RD;
            end
         end
         cas_pkg::ST_SEARCH_RD: begin
            if (ptr_ff == count_ff) begin
               // Every stored note is below the new one: it goes at the top unless the set is full.
               if (count_ff == CNT_W'(MAX_NOTES)) begin
                  dropped_in = 1'b1;
                  state_in   = done_state;
               end else begin
                  pos_in   = ptr_ff;
                  state_in = cas_pkg::ST_INSERT;
               end
            end else begin
               ram_re   = 1'b1;
               state_in = cas_pkg::ST_SEARCH_CMP;
            end
         end
         cas_pkg::ST_SEARCH_CMP: begin
            if (ram_rdata < note_ff) begin
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = cas_pkg::ST_SEARCH_RD;
            end else if (ram_rdata == note_ff) begin
               state_in = done_state;
            end else if (count_ff == CNT_W'(MAX_NOTES)) begin
               dropped_in = 1'b1;
               state_in   = done_state;
            end else begin
               pos_in   = ptr_ff;
               ptr_in   = count_ff;
               state_in = cas_pkg::ST_SHIFT_RD;
            end
         end
         cas_pkg::ST_SHIFT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec[ADDR_W-1:0];
            state_in  = cas_pkg::ST_SHIFT_WR;
         end
         cas_pkg::ST_SHIFT_WR: begin
            ram_we   = 1'b1;
            ptr_in   = ptr_dec;
            state_in = (ptr_dec == pos_ff) ? cas_pkg::ST_INSERT : cas_pkg::ST_SHIFT_RD;
         end
         cas_pkg::ST_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[ADDR_W-1:0];
            ram_wdata = note_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = done_state;
         end
         cas_pkg::ST_EMIT_SETUP: begin
            // Issues the read of the current arpeggio position. The run length is worked out
            // anew from the mode and the note count on every pass through this state.
            if ((mode_ff == cas_pkg::MODE_UP_DOWN || mode_ff == cas_pkg::MODE_DOWN_UP) &&
                count_ff > CNT_W'(2)) begin
               len_in = (n_ext << 1) - SEQ_W'(2);
            end else begin
               len_in = n_ext;
            end
            ram_re    = 1'b1;
            ram_raddr = emit_idx[ADDR_W-1:0];
            state_in  = cas_pkg::ST_EMIT_RD;
         end
         cas_pkg::ST_EMIT_RD: begin
            // The read data of the current index is valid in this state;
            // it is loaded into the output register once that register is free.
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_note    = ram_rdata;
               rsp_data_in.last_of_run = (seq_ff == len_ff - SEQ_W'(1));
               rsp_data_in.overflow    = dropped_ff;
               if (seq_ff == len_ff - SEQ_W'(1)) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = cas_pkg::ST_IDLE;
               end else begin
                  seq_in   = seq_ff + SEQ_W'(1);
                  state_in = cas_pkg::ST_EMIT_SETUP;
               end
            end
         end
         default: begin
            state_in = cas_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cas_pkg::ST_IDLE;
         mode_ff      <= cas_pkg::MODE_UP;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= cas_pkg::pattern_mode_type'(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      note_ff     <= note_in;
      end_ff      <= end_in;
      ptr_ff      <= ptr_in;
      pos_ff      <= pos_in;
      seq_ff      <= seq_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/cas_checker.sv =====
// Port-level checks of the chord arpeggio sequencer and their binding.
module cas_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input cas_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cas_pkg::rsp_type rsp_data
);

   // A result held back by the receiver stays unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   // req_ready drops after every accepted note, so notes are never accepted back to back.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("note accepted back to back");

   // A note that does not end the chord produces no result right away.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.chord_end && !rsp_valid |=> !rsp_valid)
      else $error("result without chord end");

   // An offered result always carries fully known bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result carries unknown bits");

endmodule

bind chord_arpeggio_sequencer cas_checker u_cas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the chord arpeggio sequencer with its scoreboard and stimulus.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHORD_CAP     = cas_pkg::MAX_NOTES_DEFAULT;
   // Settle time, long enough for the slowest note insertion into a full set to finish.
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_CAP     = 25;

   // The scoreboard mirrors the sorted note set of the block. Every accepted note
   // goes through the same insertion rules, and a chord end expands the set
   // into the queue of arpeggio notes that the result channel must deliver.
   class chord_tracker;
      logic [cas_pkg::NOTE_W-1:0] held_notes [CHORD_CAP];
      int                         held_count;
      bit                         note_lost;
      cas_pkg::pattern_mode_type  order;
      cas_pkg::rsp_type           pending_notes [$];
      int                         mismatches;
      int                         notes_checked;
      int                         chords_seen;
      int                         overflow_chords;

      function new();
         held_count      = 0;
         note_lost       = 1'b0;
         order           = cas_pkg::MODE_UP;
         mismatches      = 0;
         notes_checked   = 0;
         chords_seen     = 0;
         overflow_chords = 0;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
         end
      endtask

      function void take_note(cas_pkg::req_type item);
         int               pos;
         int               k;
         int               n;
         int               walk [$];
         cas_pkg::rsp_type next;
         pos = 0;
         while (pos < held_count && held_notes[pos] < item.note_number) begin
            pos++;
         end
         if (pos < held_count && held_notes[pos] == item.note_number) begin
            // A repeated note changes nothing.
         end else if (held_count >= CHORD_CAP) begin
            note_lost = 1'b1;
         end else begin
            for (k = held_count; k > pos; k--) begin
               held_notes[k] = held_notes[k-1];
            end
            held_notes[pos] = item.note_number;
            held_count++;
         end
         if (!item.chord_end) begin
            return;
         end
         n = held_count;
         case (order) inside
            cas_pkg::MODE_UP, cas_pkg::MODE_UP_DOWN: begin
               for (k = 0; k < n; k++) walk = {walk, k};
               if (order == cas_pkg::MODE_UP_DOWN) begin
                  for (k = n - 2; k > 0; k--) walk = {walk, k};
               end
            end
            default: begin
               for (k = n - 1; k >= 0; k--) walk = {walk, k};
               if (order == cas_pkg::MODE_DOWN_UP) begin
                  for (k = 1; k < n - 1; k++) walk = {walk, k};
               end
            end
         endcase
         for (k = 0; k < walk.size(); k++) begin
            next.out_note    = held_notes[walk[k]];
            next.last_of_run = (k == walk.size() - 1);
            next.overflow    = note_lost;
            pending_notes    = {pending_notes, next};
         end
         chords_seen++;
         if (note_lost) begin
            overflow_chords++;
         end
         held_count = 0;
         note_lost  = 1'b0;
      endfunction

      task check_note(cas_pkg::rsp_type got);
         cas_pkg::rsp_type want;
         if (pending_notes.size() == 0) begin
            report_mismatch($sformatf("unexpected note %0d with nothing pending",
                                      got.out_note));
            return;
         end
         want = pending_notes.pop_front();
         notes_checked++;
         if (got.out_note !== want.out_note) begin
            report_mismatch($sformatf("out_note %0d, expected %0d",
                                      got.out_note, want.out_note));
         end
         if (got.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b on note %0d",
                                      got.last_of_run, want.last_of_run, want.out_note));
         end
         if (got.overflow !== want.overflow) begin
            report_mismatch($sformatf("overflow %0b, expected %0b on note %0d",
                                      got.overflow, want.overflow, want.out_note));
         end
      endtask
   endclass

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   cas_pkg::req_type            req_data    = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   cas_pkg::rsp_type            rsp_data;
   logic                        csr_wr_en   = 1'b0;
   logic [cas_pkg::MODE_W-1:0]  csr_wr_data = '0;

   chord_tracker                tracker     = new();
   int                          idle_pct    = 0;
   int                          stall_pct   = 0;
   logic                        hold_req    = 1'b0;
   int                          hold_left   = 0;
   int                          cycle_count = 0;

   chord_arpeggio_sequencer #(.MAX_NOTES(CHORD_CAP)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The watchdog ends a run that hangs, for example when a result never shows up.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d notes still pending.",
                  cycle_count, tracker.pending_notes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side. Values read right after the edge are the ones the edge sampled,
   // so a transfer is seen exactly when valid and ready were both high. Ready is
   // then chosen for the next cycle: a long hold when the stimulus asks for one,
   // otherwise a random stall at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            tracker.check_note(rsp_data);
         end
         if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offers one note and returns at the edge where its transfer happens. Valid
   // stays high on return, so back-to-back notes never drop it within a step;
   // an idle gap lowers it first, for as long as the random draws at idle_pct ask.
   task offer_note(logic [cas_pkg::NOTE_W-1:0] note, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data.note_number <= note;
      req_data.chord_end   <= last;
      do @(posedge clock); while (!req_ready);
      tracker.take_note('{note_number: note, chord_end: last});
   endtask

   // Waits until every expected note has arrived and any insertion that emits
   // nothing has had time to finish, so the block is idle.
   task drain_block();
      req_valid <= 1'b0;
      while (tracker.pending_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_order(cas_pkg::pattern_mode_type mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.order = mode;
   endtask

   // One chord of random content. Most chords are short, some fill the set and
   // some go past it so that the overflow path is exercised. A narrow spread of
   // notes makes repeats common; a full spread reaches every note bit. Now and
   // then a stray chord end splits a chord early.
   task play_chord(output int sent);
      int                         size;
      int                         spread;
      int                         pick;
      int                         i;
      logic [cas_pkg::NOTE_W-1:0] base;
      logic                       last;
      pick = $urandom_range(99);
      if (pick < 70) size = $urandom_range(1, 6);
      else if (pick < 90) size = $urandom_range(7, CHORD_CAP);
      else size = $urandom_range(CHORD_CAP + 1, CHORD_CAP + 8);
      spread = ($urandom_range(3) == 0) ? 127 : $urandom_range(3, 30);
      base   = cas_pkg::NOTE_W'($urandom_range(127));
      for (i = 0; i < size; i++) begin
         last = (i == size - 1) || ($urandom_range(99) < 4);
         offer_note(base + cas_pkg::NOTE_W'($urandom_range(spread)), last);
      end
      sent = size;
   endtask

   task run_phase(cas_pkg::pattern_mode_type mode, int idle, int stall, int count,
                  bit squeeze);
      int done;
      int sent;
      drain_block();
      write_order(mode);
      idle_pct  = idle;
      stall_pct = stall;
      if (squeeze) begin
         hold_req <= 1'b1;
      end
      done = 0;
      while (done < count) begin
         play_chord(sent);
         done += sent;
      end
   endtask

   initial begin
      int i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part in up-down order, the mode with the most corner cases.
      write_order(cas_pkg::MODE_UP_DOWN);
      // One distinct note: it comes out once, at the top of the note range.
      offer_note(7'd127, 1'b1);
      // Two distinct notes with a repeat: the repeat is ignored and up-down
      // emits only the two ends.
      offer_note(7'd0, 1'b0);
      offer_note(7'd0, 1'b0);
      offer_note(7'd127, 1'b1);
      // A full set, then a repeat, which is not a drop, then a new note on
      // the chord end itself, which is dropped and flags overflow.
      for (i = 0; i < CHORD_CAP; i++) begin
         offer_note(cas_pkg::NOTE_W'(i * 37), 1'b0);
      end
      offer_note(7'd0, 1'b0);
      offer_note(cas_pkg::NOTE_W'(CHORD_CAP * 37), 1'b1);

      // Random phases that cover every order and every mix of idling.
      run_phase(cas_pkg::MODE_UP,      0,  0,  90, 1'b0);
      run_phase(cas_pkg::MODE_DOWN,    50, 0,  90, 1'b0);
      run_phase(cas_pkg::MODE_DOWN_UP, 0,  50, 90, 1'b0);
      run_phase(cas_pkg::MODE_UP_DOWN, 32, 32, 90, 1'b0);
      // The receiver holds off while notes keep coming, so the result register
      // fills and the block has to push back on the note channel.
      run_phase(cas_pkg::MODE_UP,      0,  0,  40, 1'b1);

      req_valid <= 1'b0;
      stall_pct = 0;
      while (tracker.pending_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d chords in all four arpeggio orders, %0d of them overflowing.",
               tracker.chords_seen, tracker.overflow_chords);
      $display("Checked %0d emitted notes and found %0d mismatches.",
               tracker.notes_checked, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
